// ===== hw/rtl/fbd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared widths, codes, command/status structs and color packing for the
// framebuffer draw engine.
// ----------------------------------------------------------------------------
package fbd_pkg;

	// memory geometry
	localparam int MEM_WORDS = 1048576;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int ADDR_W    = 28;
	localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(MEM_WORDS);

	// field widths
	localparam int CRD_W  = 12;
	localparam int DIM_W  = 13;
	localparam int PIX_W  = 32;
	localparam int KIND_W = 3;
	localparam int FMT_W  = 2;
	localparam int CIDX_W = 2;

	// command kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HLINE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_VLINE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FILL  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd5;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_FORMAT = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_PITCH  = 2'd3;

	// color formats
	localparam logic [FMT_W-1:0] FMT_ARGB = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGBA = 2'd1;
	localparam logic [FMT_W-1:0] FMT_BGRA = 2'd2;
	localparam logic [FMT_W-1:0] FMT_ABGR = 2'd3;

	// datapath memory operation
	typedef enum logic [2:0] {
		OP_NONE,
		OP_FILL,
		OP_READ,
		OP_SNAP,
		OP_CLEAR,
		OP_COPY
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_src;
		logic mul_dst;
		logic rewind;
		logic step;
		op_t  op;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic              reject;
		logic              empty;
		logic [KIND_W-1:0] kind;
		logic              last;
	} sts_t;

	// reorder r,g,b,a channels into the configured format
	function automatic logic [PIX_W-1:0] pack_color(input logic [FMT_W-1:0] fmt,
		input logic [PIX_W-1:0] c);
		logic [7:0] r, g, b, a;
		logic [PIX_W-1:0] res;
		r = c[31:24];
		g = c[23:16];
		b = c[15:8];
		a = c[7:0];
		case (fmt)
			FMT_ARGB: res = {a, r, g, b};
			FMT_RGBA: res = {r, g, b, a};
			FMT_BGRA: res = {b, g, r, a};
			default:  res = {a, b, g, r};
		endcase
		return res;
	endfunction

endpackage

// ===== hw/rtl/fbd_ram.sv =====
// ----------------------------------------------------------------------------
// fbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbd_ctrl
// Command sequencer: setup multiplies, pixel scan passes and result strobe.
// ----------------------------------------------------------------------------
module fbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  fbd_pkg::sts_t sts,
	output fbd_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_MULD,
		S_PREP,
		S_FILL,
		S_READ,
		S_RWAIT,
		S_SNAP,
		S_CLEAR,
		S_COPY,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = fbd_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.mul_src = 1'b1;
				state_d     = (sts.reject || sts.empty) ? S_DONE : S_MULD;
			end
			S_MULD: begin
				cmd.mul_dst = 1'b1;
				state_d     = S_PREP;
			end
			S_PREP: begin
				cmd.rewind = 1'b1;
				if (sts.kind == fbd_pkg::KIND_READ) begin
					state_d = S_READ;
				end else if (sts.kind == fbd_pkg::KIND_MOVE) begin
					state_d = S_SNAP;
				end else begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.op   = fbd_pkg::OP_FILL;
				cmd.step = 1'b1;
				if (sts.last) state_d = S_DONE;
			end
			S_READ: begin
				cmd.op  = fbd_pkg::OP_READ;
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.capture = 1'b1;
				state_d     = S_DONE;
			end
			S_SNAP: begin
				cmd.op   = fbd_pkg::OP_SNAP;
				cmd.step = 1'b1;
				if (sts.last) state_d = S_CLEAR;
			end
			S_CLEAR: begin
				cmd.op   = fbd_pkg::OP_CLEAR;
				cmd.step = 1'b1;
				if (sts.last) state_d = S_COPY;
			end
			S_COPY: begin
				cmd.op   = fbd_pkg::OP_COPY;
				cmd.step = 1'b1;
				if (sts.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted command did not raise busy");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("engine still busy after result");

endmodule

// ===== hw/rtl/fbd_dp.sv =====
// ----------------------------------------------------------------------------
// fbd_dp
// Datapath: config registers, command capture, bounds and clipping, address
// scan and memory port drive.
// ----------------------------------------------------------------------------
module fbd_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	// config
	input  logic                         cfg_valid,
	input  logic [fbd_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [fbd_pkg::DIM_W-1:0]    cfg_data,
	// item
	input  logic [fbd_pkg::KIND_W-1:0]   kind,
	input  logic [fbd_pkg::CRD_W-1:0]    pos_x,
	input  logic [fbd_pkg::CRD_W-1:0]    pos_y,
	input  logic [fbd_pkg::DIM_W-1:0]    span_w,
	input  logic [fbd_pkg::DIM_W-1:0]    span_h,
	input  logic [fbd_pkg::CRD_W-1:0]    dest_x,
	input  logic [fbd_pkg::CRD_W-1:0]    dest_y,
	input  logic [fbd_pkg::PIX_W-1:0]    color,
	input  logic                         pack_channels,
	// control
	input  fbd_pkg::cmd_t                cmd,
	output fbd_pkg::sts_t                sts,
	// frame memory
	output logic                         fr_we,
	output logic [fbd_pkg::MEM_AW-1:0]   fr_waddr,
	output logic [fbd_pkg::PIX_W-1:0]    fr_wdata,
	output logic                         fr_re,
	output logic [fbd_pkg::MEM_AW-1:0]   fr_raddr,
	input  logic [fbd_pkg::PIX_W-1:0]    fr_rdata,
	// snapshot memory
	output logic                         sn_we,
	output logic [fbd_pkg::MEM_AW-1:0]   sn_waddr,
	output logic [fbd_pkg::PIX_W-1:0]    sn_wdata,
	output logic                         sn_re,
	output logic [fbd_pkg::MEM_AW-1:0]   sn_raddr,
	input  logic [fbd_pkg::PIX_W-1:0]    sn_rdata,
	// result
	output logic                         status,
	output logic [fbd_pkg::PIX_W-1:0]    read_data
);

	localparam int DW = fbd_pkg::DIM_W;
	localparam int AW = fbd_pkg::ADDR_W;
	localparam int SW = fbd_pkg::DIM_W + 1;

	logic [fbd_pkg::FMT_W-1:0]  fmt_q;
	logic [DW-1:0]              fw_q, fh_q, pitch_q;

	logic [fbd_pkg::KIND_W-1:0] kind_q;
	logic [fbd_pkg::CRD_W-1:0]  x_q, y_q, nx_q, ny_q;
	logic [DW-1:0]              ncol_q, nrow_q;
	logic [fbd_pkg::PIX_W-1:0]  color_q;
	logic                       reject_q, empty_q;

	logic [AW-1:0]              src_org_q, dst_org_q;
	logic [AW-1:0]              srow_q, drow_q, off_q;
	logic [DW-1:0]              col_q, row_q;

	logic                       rd_ok_s1;
	logic                       sn_we_s1;
	logic [fbd_pkg::MEM_AW-1:0] sn_addr_s1;
	logic                       cp_we_s1, cp_ok_s1;
	logic [fbd_pkg::MEM_AW-1:0] cp_addr_s1;
	logic [fbd_pkg::PIX_W-1:0]  rdata_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= fbd_pkg::FMT_ARGB;
			fw_q    <= DW'(640);
			fh_q    <= DW'(480);
			pitch_q <= DW'(640);
		end else if (cfg_valid) begin
			case (cfg_index)
				fbd_pkg::CFG_FORMAT: fmt_q   <= cfg_data[fbd_pkg::FMT_W-1:0];
				fbd_pkg::CFG_WIDTH:  fw_q    <= cfg_data;
				fbd_pkg::CFG_HEIGHT: fh_q    <= cfg_data;
				fbd_pkg::CFG_PITCH:  pitch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bounds check and clipping of the incoming command
	logic [SW-1:0] xw, yw, yh, nxw, nyh, fw_e, fh_e, xe_w, ye_w, ye_h;
	logic          start_out, move_bad;
	logic [DW-1:0] clip_cw, clip_rw, clip_rh, ncol_d, nrow_d;
	logic          reject_d;

	always_comb begin
		fw_e      = SW'(fw_q);
		fh_e      = SW'(fh_q);
		xw        = SW'(pos_x) + SW'(span_w);
		yw        = SW'(pos_y) + SW'(span_w);
		yh        = SW'(pos_y) + SW'(span_h);
		nxw       = SW'(dest_x) + SW'(span_w);
		nyh       = SW'(dest_y) + SW'(span_h);
		xe_w      = (xw > fw_e) ? fw_e : xw;
		ye_w      = (yw > fh_e) ? fh_e : yw;
		ye_h      = (yh > fh_e) ? fh_e : yh;
		clip_cw   = DW'(xe_w - SW'(pos_x));
		clip_rw   = DW'(ye_w - SW'(pos_y));
		clip_rh   = DW'(ye_h - SW'(pos_y));
		start_out = (DW'(pos_x) >= fw_q) || (DW'(pos_y) >= fh_q);
		move_bad  = (xw > fw_e) || (yh > fh_e) || (nxw > fw_e) || (nyh > fh_e);
		case (kind)
			fbd_pkg::KIND_PIXEL, fbd_pkg::KIND_READ: begin
				ncol_d = DW'(1);  nrow_d = DW'(1);  reject_d = start_out;
			end
			fbd_pkg::KIND_HLINE: begin
				ncol_d = clip_cw; nrow_d = DW'(1);  reject_d = start_out;
			end
			fbd_pkg::KIND_VLINE: begin
				ncol_d = DW'(1);  nrow_d = clip_rw; reject_d = start_out;
			end
			fbd_pkg::KIND_FILL: begin
				ncol_d = clip_cw; nrow_d = clip_rh; reject_d = start_out;
			end
			fbd_pkg::KIND_MOVE: begin
				ncol_d = span_w;  nrow_d = span_h;  reject_d = move_bad;
			end
			default: begin
				ncol_d = '0;      nrow_d = '0;      reject_d = 1'b0;
			end
		endcase
	end

	// command capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			x_q     <= pos_x;
			y_q     <= pos_y;
			nx_q    <= dest_x;
			ny_q    <= dest_y;
			ncol_q  <= ncol_d;
			nrow_q  <= nrow_d;
			color_q <= pack_channels ? fbd_pkg::pack_color(fmt_q, color) : color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q <= 1'b0;
			empty_q  <= 1'b0;
		end else if (cmd.load) begin
			reject_q <= reject_d;
			empty_q  <= (ncol_d == '0) || (nrow_d == '0);
		end
	end

	// row base multiply, source then destination
	logic [fbd_pkg::CRD_W-1:0] mul_a;
	logic [AW-1:0]             mul_p;
	assign mul_a = cmd.mul_dst ? ny_q : y_q;
	assign mul_p = AW'(mul_a) * AW'(pitch_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_src) src_org_q <= mul_p;
		if (cmd.mul_dst) dst_org_q <= mul_p;
	end

	// raster scan over the rectangle, wraps to the origin after the last pixel
	logic col_last, row_last;
	assign col_last = (col_q == ncol_q - DW'(1));
	assign row_last = (row_q == nrow_q - DW'(1));

	always_ff @(posedge clk) begin
		if (cmd.rewind || (cmd.step && col_last && row_last)) begin
			col_q  <= '0;
			row_q  <= '0;
			srow_q <= src_org_q;
			drow_q <= dst_org_q;
			off_q  <= '0;
		end else if (cmd.step) begin
			if (col_last) begin
				col_q  <= '0;
				row_q  <= row_q + DW'(1);
				srow_q <= srow_q + AW'(pitch_q);
				drow_q <= drow_q + AW'(pitch_q);
				off_q  <= off_q + AW'(pitch_q);
			end else begin
				col_q <= col_q + DW'(1);
			end
		end
	end

	// pixel addresses
	logic [AW-1:0] src_addr, dst_addr, snap_idx;
	logic          src_ok, dst_ok;
	assign src_addr = srow_q + AW'(x_q) + AW'(col_q);
	assign dst_addr = drow_q + AW'(nx_q) + AW'(col_q);
	assign snap_idx = off_q + AW'(col_q);
	assign src_ok   = (src_addr < fbd_pkg::MEM_LIMIT);
	assign dst_ok   = (dst_addr < fbd_pkg::MEM_LIMIT);

	// read-latency stage for snapshot, copy and pixel read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_we_s1 <= 1'b0;
			cp_we_s1 <= 1'b0;
		end else begin
			sn_we_s1 <= (cmd.op == fbd_pkg::OP_SNAP) && src_ok;
			cp_we_s1 <= (cmd.op == fbd_pkg::OP_COPY) && dst_ok;
		end
	end

	always_ff @(posedge clk) begin
		rd_ok_s1   <= src_ok;
		sn_addr_s1 <= snap_idx[fbd_pkg::MEM_AW-1:0];
		cp_ok_s1   <= src_ok;
		cp_addr_s1 <= dst_addr[fbd_pkg::MEM_AW-1:0];
	end

	// frame memory drive
	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = src_addr[fbd_pkg::MEM_AW-1:0];
		fr_wdata = color_q;
		if (cp_we_s1) begin
			fr_we    = 1'b1;
			fr_waddr = cp_addr_s1;
			fr_wdata = cp_ok_s1 ? sn_rdata : '0;
		end else if (cmd.op == fbd_pkg::OP_FILL) begin
			fr_we = src_ok;
		end else if (cmd.op == fbd_pkg::OP_CLEAR) begin
			fr_we    = src_ok;
			fr_wdata = '0;
		end
	end

	assign fr_re    = ((cmd.op == fbd_pkg::OP_READ) || (cmd.op == fbd_pkg::OP_SNAP)) && src_ok;
	assign fr_raddr = src_addr[fbd_pkg::MEM_AW-1:0];

	// snapshot memory drive
	assign sn_we    = sn_we_s1;
	assign sn_waddr = sn_addr_s1;
	assign sn_wdata = fr_rdata;
	assign sn_re    = (cmd.op == fbd_pkg::OP_COPY) && src_ok;
	assign sn_raddr = snap_idx[fbd_pkg::MEM_AW-1:0];

	// read result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_q <= '0;
		end else if (cmd.capture) begin
			rdata_q <= rd_ok_s1 ? fr_rdata : '0;
		end
	end

	assign status    = reject_q;
	assign read_data = rdata_q;

	assign sts.reject = reject_q;
	assign sts.empty  = empty_q;
	assign sts.kind   = kind_q;
	assign sts.last   = col_last && row_last;

	// checks
	a_frame_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(fr_we && fr_re)) else $error("frame read and write in one cycle");
	a_snap_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(sn_we && sn_re)) else $error("snapshot read and write in one cycle");
	a_copy_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cp_we_s1 |-> $past(cmd.op == fbd_pkg::OP_COPY)) else $error("stray copy write");

endmodule

// ===== hw/rtl/framebuffer_draw_engine_top.sv =====
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_top
// 2D draw engine: pixel, lines, rectangle fill, rectangle move and pixel read
// over a word-addressed frame memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on status and read_data for one cycle with done high, and must be
// captured then. The engine writes one pixel per cycle. A move walks the
// rectangle three times (snapshot of the source, clearing of the source, copy
// to the destination), since the frame memory has a single write port.
// Configuration writes are always ready and must only be issued while busy
// is low.
module framebuffer_draw_engine_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [fbd_pkg::KIND_W-1:0]  kind,
	input  logic [fbd_pkg::CRD_W-1:0]   pos_x,
	input  logic [fbd_pkg::CRD_W-1:0]   pos_y,
	input  logic [fbd_pkg::DIM_W-1:0]   span_w,
	input  logic [fbd_pkg::DIM_W-1:0]   span_h,
	input  logic [fbd_pkg::CRD_W-1:0]   dest_x,
	input  logic [fbd_pkg::CRD_W-1:0]   dest_y,
	input  logic [fbd_pkg::PIX_W-1:0]   color,
	input  logic                        pack_channels,
	// result
	output logic                        done,
	output logic                        status,
	output logic [fbd_pkg::PIX_W-1:0]   read_data,
	// config write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fbd_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [fbd_pkg::DIM_W-1:0]   cfg_data
);

	fbd_pkg::cmd_t              cmd;
	fbd_pkg::sts_t              sts;
	logic                       fr_we, fr_re, sn_we, sn_re;
	logic [fbd_pkg::MEM_AW-1:0] fr_waddr, fr_raddr, sn_waddr, sn_raddr;
	logic [fbd_pkg::PIX_W-1:0]  fr_wdata, fr_rdata, sn_wdata, sn_rdata;

	assign cfg_ready = 1'b1;

	// sequencer
	fbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath
	fbd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.span_w        (span_w),
		.span_h        (span_h),
		.dest_x        (dest_x),
		.dest_y        (dest_y),
		.color         (color),
		.pack_channels (pack_channels),
		.cmd           (cmd),
		.sts           (sts),
		.fr_we         (fr_we),
		.fr_waddr      (fr_waddr),
		.fr_wdata      (fr_wdata),
		.fr_re         (fr_re),
		.fr_raddr      (fr_raddr),
		.fr_rdata      (fr_rdata),
		.sn_we         (sn_we),
		.sn_waddr      (sn_waddr),
		.sn_wdata      (sn_wdata),
		.sn_re         (sn_re),
		.sn_raddr      (sn_raddr),
		.sn_rdata      (sn_rdata),
		.status        (status),
		.read_data     (read_data)
	);

	// frame memory
	fbd_ram #(
		.WIDTH (fbd_pkg::PIX_W),
		.DEPTH (fbd_pkg::MEM_WORDS)
	) u_frame_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.re    (fr_re),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	// move snapshot memory
	fbd_ram #(
		.WIDTH (fbd_pkg::PIX_W),
		.DEPTH (fbd_pkg::MEM_WORDS)
	) u_snap_ram (
		.clk   (clk),
		.we    (sn_we),
		.waddr (sn_waddr),
		.wdata (sn_wdata),
		.re    (sn_re),
		.raddr (sn_raddr),
		.rdata (sn_rdata)
	);

endmodule

// ===== sim/framebuffer_draw_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_top_tb
// Self-checking bench for the draw engine: directed and random pixel, line,
// fill, move and read commands over several frame geometries and color
// formats, checked against a frame memory model kept in the bench.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_top_tb;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int PHASE_COUNT    = 8;
	localparam int RAND_PER_PHASE = 142;
	localparam logic [fbd_pkg::KIND_W-1:0] KIND_UNUSED_A = 3'd6;

	typedef struct packed {
		logic [fbd_pkg::KIND_W-1:0] kind;
		logic [fbd_pkg::CRD_W-1:0]  pos_x;
		logic [fbd_pkg::CRD_W-1:0]  pos_y;
		logic [fbd_pkg::DIM_W-1:0]  span_w;
		logic [fbd_pkg::DIM_W-1:0]  span_h;
		logic [fbd_pkg::CRD_W-1:0]  dest_x;
		logic [fbd_pkg::CRD_W-1:0]  dest_y;
		logic [fbd_pkg::PIX_W-1:0]  color;
		logic                       pack;
	} draw_cmd_t;

	typedef struct packed {
		logic                      status;
		logic [fbd_pkg::PIX_W-1:0] read_data;
	} draw_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [fbd_pkg::KIND_W-1:0] kind;
	logic [fbd_pkg::CRD_W-1:0]  pos_x, pos_y, dest_x, dest_y;
	logic [fbd_pkg::DIM_W-1:0]  span_w, span_h;
	logic [fbd_pkg::PIX_W-1:0]  color;
	logic                       pack_channels;
	logic                       done;
	logic                       status;
	logic [fbd_pkg::PIX_W-1:0]  read_data;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [fbd_pkg::CIDX_W-1:0] cfg_index;
	logic [fbd_pkg::DIM_W-1:0]  cfg_data;

	framebuffer_draw_engine_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .span_w(span_w), .span_h(span_h),
		.dest_x(dest_x), .dest_y(dest_y), .color(color), .pack_channels(pack_channels),
		.done(done), .status(status), .read_data(read_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// model of the engine: frame memory (entry exists once written) and registers
	logic [fbd_pkg::PIX_W-1:0] pix_mem [longint];
	logic [fbd_pkg::FMT_W-1:0] fmt_reg;
	longint                    width_reg, height_reg, pitch_reg;

	draw_cmd_t    cmd_q [$];
	draw_result_t exp_q [$];
	int  pushed_n, accepted_n, checked_n, error_n;
	int  read_n, move_n, reject_n;
	bit  burst_mode;

	// reorder r,g,b,a channels by the current format
	function automatic logic [fbd_pkg::PIX_W-1:0] swizzle(logic [fbd_pkg::PIX_W-1:0] c);
		logic [7:0] r, g, b, a;
		{r, g, b, a} = c;
		case (fmt_reg)
			fbd_pkg::FMT_ARGB: return {a, r, g, b};
			fbd_pkg::FMT_RGBA: return {r, g, b, a};
			fbd_pkg::FMT_BGRA: return {b, g, r, a};
			default:           return {a, b, g, r};
		endcase
	endfunction

	function automatic void put_pixel(longint addr, logic [fbd_pkg::PIX_W-1:0] v);
		if (addr < fbd_pkg::MEM_WORDS)
			pix_mem[addr] = v;
	endfunction

	function automatic logic [fbd_pkg::PIX_W-1:0] get_pixel(longint addr);
		if (addr < fbd_pkg::MEM_WORDS && pix_mem.exists(addr))
			return pix_mem[addr];
		return '0;
	endfunction

	function automatic void fill_box(longint x0, longint y0, longint x1, longint y1,
		logic [fbd_pkg::PIX_W-1:0] v);
		for (longint j = y0; j < y1; j++)
			for (longint i = x0; i < x1; i++)
				put_pixel(j * pitch_reg + i, v);
	endfunction

	function automatic bit move_fits(draw_cmd_t c);
		return c.pos_x + c.span_w <= width_reg && c.pos_y + c.span_h <= height_reg &&
			c.dest_x + c.span_w <= width_reg && c.dest_y + c.span_h <= height_reg;
	endfunction

	// expected result and memory update for one accepted command
	function automatic draw_result_t apply_command(draw_cmd_t c);
		draw_result_t res;
		logic [fbd_pkg::PIX_W-1:0] px;
		logic [fbd_pkg::PIX_W-1:0] snap [$];
		longint x, y, xe, ye, a;
		int k;
		res = '0;
		x = c.pos_x;
		y = c.pos_y;
		px = c.pack ? swizzle(c.color) : c.color;
		if (c.kind <= fbd_pkg::KIND_FILL || c.kind == fbd_pkg::KIND_READ) begin
			if (x >= width_reg || y >= height_reg) begin
				res.status = 1'b1;
			end else begin
				xe = (x + c.span_w > width_reg) ? width_reg : x + c.span_w;
				ye = (y + c.span_w > height_reg) ? height_reg : y + c.span_w;
				case (c.kind)
					fbd_pkg::KIND_PIXEL: put_pixel(y * pitch_reg + x, px);
					fbd_pkg::KIND_HLINE: fill_box(x, y, xe, y + 1, px);
					fbd_pkg::KIND_VLINE: fill_box(x, y, x + 1, ye, px);
					fbd_pkg::KIND_FILL: begin
						ye = (y + c.span_h > height_reg) ? height_reg : y + c.span_h;
						fill_box(x, y, xe, ye, px);
					end
					default: res.read_data = get_pixel(y * pitch_reg + x);
				endcase
			end
		end else if (c.kind == fbd_pkg::KIND_MOVE) begin
			if (!move_fits(c)) begin
				res.status = 1'b1;
			end else if (c.span_w != 0 && c.span_h != 0) begin
				// old source contents first, then clear, then copy out
				for (longint r = 0; r < c.span_h; r++)
					for (longint q = 0; q < c.span_w; q++)
						snap.push_back(get_pixel((y + r) * pitch_reg + x + q));
				for (longint r = 0; r < c.span_h; r++)
					for (longint q = 0; q < c.span_w; q++)
						put_pixel((y + r) * pitch_reg + x + q, '0);
				k = 0;
				for (longint r = 0; r < c.span_h; r++)
					for (longint q = 0; q < c.span_w; q++) begin
						a = (c.dest_y + r) * pitch_reg + c.dest_x + q;
						put_pixel(a, snap[k]);
						k++;
					end
			end
		end
		return res;
	endfunction

	// true when the command reads no memory entry that was never written
	function automatic bit reads_known(draw_cmd_t c);
		longint a;
		if (c.kind == fbd_pkg::KIND_READ) begin
			if (c.pos_x >= width_reg || c.pos_y >= height_reg)
				return 1'b1;
			a = c.pos_y * pitch_reg + c.pos_x;
			return a >= fbd_pkg::MEM_WORDS || pix_mem.exists(a);
		end
		if (c.kind == fbd_pkg::KIND_MOVE && move_fits(c) && c.span_w != 0 &&
			c.span_h != 0) begin
			for (longint r = 0; r < c.span_h; r++)
				for (longint q = 0; q < c.span_w; q++) begin
					a = (c.pos_y + r) * pitch_reg + c.pos_x + q;
					if (a < fbd_pkg::MEM_WORDS && !pix_mem.exists(a))
						return 1'b0;
				end
		end
		return 1'b1;
	endfunction

	// wait until every queued command has been taken by the engine
	task automatic drain_commands();
		@(negedge clk);
		while (cmd_q.size() != 0 || accepted_n != pushed_n)
			@(negedge clk);
	endtask

	// queue a command; unsafe reads become pixel writes of the same spot, unsafe moves become fills
	task automatic issue(draw_cmd_t c);
		if (c.kind == fbd_pkg::KIND_READ || c.kind == fbd_pkg::KIND_MOVE) begin
			drain_commands();
			if (!reads_known(c)) begin
				if (c.kind == fbd_pkg::KIND_READ) begin
					c.kind = fbd_pkg::KIND_PIXEL;
				end else begin
					c.kind = fbd_pkg::KIND_FILL;
					c.span_w = fbd_pkg::DIM_W'(c.span_w % 17);
					c.span_h = fbd_pkg::DIM_W'(c.span_h % 17);
				end
			end
		end
		if (c.kind == fbd_pkg::KIND_READ)
			read_n++;
		if (c.kind == fbd_pkg::KIND_MOVE)
			move_n++;
		cmd_q.push_back(c);
		pushed_n++;
	endtask

	// one register write, only while the engine is idle
	task automatic write_reg(logic [fbd_pkg::CIDX_W-1:0] idx,
		logic [fbd_pkg::DIM_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			fbd_pkg::CFG_FORMAT: fmt_reg = val[fbd_pkg::FMT_W-1:0];
			fbd_pkg::CFG_WIDTH:  width_reg = val;
			fbd_pkg::CFG_HEIGHT: height_reg = val;
			default:             pitch_reg = val;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(logic [fbd_pkg::FMT_W-1:0] f, int w, int h, int p);
		drain_commands();
		while (exp_q.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(fbd_pkg::CFG_FORMAT,
			fbd_pkg::DIM_W'({fbd_pkg::DIM_W'($urandom) >> fbd_pkg::FMT_W, f}));
		write_reg(fbd_pkg::CFG_WIDTH, fbd_pkg::DIM_W'(w));
		write_reg(fbd_pkg::CFG_HEIGHT, fbd_pkg::DIM_W'(h));
		write_reg(fbd_pkg::CFG_PITCH, fbd_pkg::DIM_W'(p));
	endtask

	function automatic logic [fbd_pkg::CRD_W-1:0] pick_coord(longint lim);
		int r;
		longint v;
		r = $urandom_range(0, 99);
		if (r < 60)
			v = $urandom_range(0, (lim < 16 ? lim : 16) + 1);
		else if (r < 82)
			v = lim + $urandom_range(0, 3) - 2;
		else
			v = $urandom_range(0, 4095);
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return fbd_pkg::CRD_W'(v);
	endfunction

	function automatic logic [fbd_pkg::DIM_W-1:0] pick_span(longint lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return fbd_pkg::DIM_W'($urandom_range(0, 8));
		if (r < 75)
			return fbd_pkg::DIM_W'($urandom_range(0, (lim > 4094 ? 4094 : lim) + 2));
		if (r < 88)
			return $urandom_range(0, 1) ? fbd_pkg::DIM_W'(4096) : fbd_pkg::DIM_W'(4095);
		return fbd_pkg::DIM_W'($urandom_range(0, 4096));
	endfunction

	function automatic draw_cmd_t random_command();
		draw_cmd_t c;
		int r;
		longint cw, ch, room;
		r = $urandom_range(0, 99);
		c.kind   = r < 14 ? fbd_pkg::KIND_PIXEL : r < 28 ? fbd_pkg::KIND_HLINE :
			r < 42 ? fbd_pkg::KIND_VLINE : r < 56 ? fbd_pkg::KIND_FILL :
			r < 74 ? fbd_pkg::KIND_MOVE : r < 95 ? fbd_pkg::KIND_READ :
			fbd_pkg::KIND_W'($urandom_range(KIND_UNUSED_A, 7));
		c.pos_x  = pick_coord(width_reg);
		c.pos_y  = pick_coord(height_reg);
		c.span_w = pick_span(width_reg);
		c.span_h = pick_span(height_reg);
		c.dest_x = fbd_pkg::CRD_W'($urandom);
		c.dest_y = fbd_pkg::CRD_W'($urandom);
		c.color  = $urandom;
		c.pack   = 1'($urandom_range(0, 1));
		if (c.kind == fbd_pkg::KIND_MOVE && $urandom_range(0, 99) < 75) begin
			// well-formed move, often overlapping its source
			c.span_w = fbd_pkg::DIM_W'($urandom_range(1, 8));
			c.span_h = fbd_pkg::DIM_W'($urandom_range(1, 8));
			if (width_reg >= c.span_w && height_reg >= c.span_h) begin
				room = width_reg - c.span_w;
				c.pos_x = fbd_pkg::CRD_W'($urandom_range(0, room > 24 ? 24 : room));
				c.dest_x = fbd_pkg::CRD_W'((c.pos_x + 4 <= room) ?
					c.pos_x + $urandom_range(0, 4) :
					$urandom_range(0, room > 24 ? 24 : room));
				room = height_reg - c.span_h;
				c.pos_y = fbd_pkg::CRD_W'($urandom_range(0, room > 24 ? 24 : room));
				c.dest_y = fbd_pkg::CRD_W'((c.pos_y + 4 <= room) ?
					c.pos_y + $urandom_range(0, 4) :
					$urandom_range(0, room > 24 ? 24 : room));
			end
		end
		if (c.kind == fbd_pkg::KIND_MOVE && c.span_w * c.span_h > 256) begin
			c.span_w = fbd_pkg::DIM_W'(c.span_w % 16);
			c.span_h = fbd_pkg::DIM_W'(c.span_h % 16);
		end
		// keep fills to a bounded pixel count
		if (c.kind == fbd_pkg::KIND_FILL) begin
			cw = (c.pos_x + c.span_w > width_reg) ? width_reg - c.pos_x : c.span_w;
			ch = (c.pos_y + c.span_h > height_reg) ? height_reg - c.pos_y : c.span_h;
			if (cw > 0 && ch > 0 && cw * ch > 4096) begin
				c.span_w = fbd_pkg::DIM_W'(c.span_w % 64);
				c.span_h = fbd_pkg::DIM_W'(c.span_h % 64);
			end
		end
		return c;
	endfunction

	function automatic draw_cmd_t mk(logic [fbd_pkg::KIND_W-1:0] k, int x, int y, int w,
		int h, int nx, int ny, logic [fbd_pkg::PIX_W-1:0] col, logic pk);
		draw_cmd_t c;
		c.kind = k;
		c.pos_x = fbd_pkg::CRD_W'(x);
		c.pos_y = fbd_pkg::CRD_W'(y);
		c.span_w = fbd_pkg::DIM_W'(w);
		c.span_h = fbd_pkg::DIM_W'(h);
		c.dest_x = fbd_pkg::CRD_W'(nx);
		c.dest_y = fbd_pkg::CRD_W'(ny);
		c.color = col;
		c.pack = pk;
		return c;
	endfunction

	// driver: command beats with random gaps, or none in burst mode
	draw_cmd_t cur_cmd;
	int        gap_cnt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= '0;
			pos_x <= '0;
			pos_y <= '0;
			span_w <= '0;
			span_h <= '0;
			dest_x <= '0;
			dest_y <= '0;
			color <= '0;
			pack_channels <= 1'b0;
			gap_cnt = 0;
		end else begin
			if (start && !busy) begin
				exp_q.push_back(apply_command(cur_cmd));
				accepted_n++;
			end
			if (!start || !busy) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					start <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					kind <= cur_cmd.kind;
					pos_x <= cur_cmd.pos_x;
					pos_y <= cur_cmd.pos_y;
					span_w <= cur_cmd.span_w;
					span_h <= cur_cmd.span_h;
					dest_x <= cur_cmd.dest_x;
					dest_y <= cur_cmd.dest_y;
					color <= cur_cmd.color;
					pack_channels <= cur_cmd.pack;
					start <= 1'b1;
					gap_cnt = burst_mode ? 0 : $urandom_range(0, 16);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && done) begin
			if (exp_q.size() == 0) begin
				$display("%0t: result with nothing expected: status %0b data %h",
					$time, status, read_data);
				error_n++;
			end else begin
				want = exp_q.pop_front();
				checked_n++;
				if (want.status)
					reject_n++;
				if (status !== want.status) begin
					$display("%0t: status expected %0b actual %0b", $time, want.status, status);
					error_n++;
				end
				if (read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h", $time, want.read_data,
						read_data);
					error_n++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	int idle_cycles;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress, %0d results still expected", $time, exp_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		int geo [PHASE_COUNT][4];
		geo = '{'{0, 640, 480, 640}, '{1, 16, 16, 16}, '{2, 0, 0, 0},
			'{3, 4096, 4096, 4096}, '{1, 37, 20, 40}, '{2, 20, 30, 17},
			'{0, 1, 1, 1}, '{3, 4096, 2, 0}};
		fmt_reg = fbd_pkg::FMT_ARGB;
		width_reg = 640;
		height_reg = 480;
		pitch_reg = 640;
		burst_mode = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, rejects, clipping, empty spans, moves, reads, unused kinds
		issue(mk(fbd_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 0, 32'h11223344, 1'b0));
		issue(mk(fbd_pkg::KIND_PIXEL, 639, 479, 0, 0, 4095, 4095, 32'hFFFFFFFF, 1'b1));
		issue(mk(fbd_pkg::KIND_PIXEL, 640, 0, 0, 0, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_HLINE, 0, 4095, 5, 0, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_HLINE, 2, 1, 0, 0, 0, 0, 32'hA5A5A5A5, 1'b0));
		issue(mk(fbd_pkg::KIND_HLINE, 630, 2, 4096, 0, 0, 0, 32'h01020304, 1'b1));
		issue(mk(fbd_pkg::KIND_VLINE, 5, 470, 4096, 0, 0, 0, 32'h55AA55AA, 1'b0));
		issue(mk(fbd_pkg::KIND_VLINE, 6, 3, 0, 0, 0, 0, 32'h1, 1'b0));
		issue(mk(fbd_pkg::KIND_FILL, 1, 1, 4, 3, 0, 0, 32'hDEADBEEF, 1'b1));
		issue(mk(fbd_pkg::KIND_FILL, 3, 3, 6, 0, 0, 0, 32'h2, 1'b0));
		issue(mk(fbd_pkg::KIND_FILL, 636, 477, 4096, 4096, 0, 0, 32'h3, 1'b0));
		issue(mk(fbd_pkg::KIND_MOVE, 638, 0, 4, 1, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_MOVE, 0, 0, 0, 4, 3, 3, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_MOVE, 0, 0, 4, 3, 2, 1, 32'h0, 1'b1));
		issue(mk(fbd_pkg::KIND_MOVE, 2, 1, 4, 3, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_READ, 3, 2, 0, 0, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_READ, 639, 479, 0, 0, 0, 0, 32'h0, 1'b0));
		issue(mk(fbd_pkg::KIND_READ, 4095, 4095, 0, 0, 0, 0, 32'h0, 1'b0));
		issue(mk(KIND_UNUSED_A, 1, 1, 1, 1, 1, 1, 32'h5, 1'b1));
		issue(mk(3'd7, 4095, 4095, 4096, 4096, 4095, 4095, 32'hFFFFFFFF, 1'b1));

		// random phases over several geometries and formats
		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_geometry(fbd_pkg::FMT_W'(geo[p][0]), geo[p][1], geo[p][2], geo[p][3]);
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (n % 40 == 0)
					burst_mode = $urandom_range(0, 2) == 0;
				issue(random_command());
			end
		end

		drain_commands();
		while (exp_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		$display("covered %0d commands (%0d reads, %0d moves, %0d rejected) over %0d geometries",
			accepted_n, read_n, move_n, reject_n, PHASE_COUNT + 1);
		$display("%0d results checked, %0d mismatches", checked_n, error_n);
		if (error_n == 0 && exp_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
